// ===== hw/rtl/lca_pkg.sv =====
// Shared constants for the Life cellular automaton unit.
`timescale 1ns / 1ps
package lca_pkg;
  localparam int unsigned MAX_SIZE = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] REG_WRAP_MODE   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GRID_WIDTH  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GRID_HEIGHT = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LOAD_WIDTH  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LOAD_HEIGHT = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_GENERATIONS = 3'd5;
  localparam int unsigned SizeW = 7;
  localparam int unsigned GenW = 16;
endpackage

// ===== hw/rtl/life_cellular_automaton_unit.sv =====
// Top level of the Life cellular automaton unit: load, evolve and crop a bit grid.
//
//   channel | direction | signals
//   in      | input     | in_valid, in_ready, in_row_bits
//   out     | output    | out_valid, out_ready, out_crop_width, out_crop_height,
//           |           | out_row_index, out_row_bits_res, out_last
//   cfg     | input     | cfg_we, cfg_idx, cfg_data
//
// Each row request passes through IDLE and LOAD. After the closing row, a mask pass reads,
// then writes each row, zeroing rows not loaded or beyond the grid height; then one pass
// per generation follows (one row update a cycle through a single shared row unit over
// two row memories), then a live-bound scan, then the result rows. Reset is synchronous,
// active low; grid contents need no clearing pass. out_ready low holds the current result
// and the emit.
`timescale 1ns / 1ps
module life_cellular_automaton_unit
  import lca_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [63:0]         in_row_bits,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SizeW-1:0]    out_crop_width,
  output logic [SizeW-1:0]    out_crop_height,
  output logic [SizeW-1:0]    out_row_index,
  output logic [63:0]         out_row_bits_res,
  output logic                out_last,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data
);
  localparam int unsigned AW = $clog2(MAX_SIZE);
  localparam logic [SizeW-1:0] MaxSz = SizeW'(MAX_SIZE);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_MASK, S_GEN, S_SCAN, S_EMIT
  } state_t;

  state_t           state_r;
  logic             wrap_r;
  logic [SizeW-1:0] gw_cfg_r, gh_cfg_r, lw_cfg_r, lh_cfg_r;
  logic [GenW-1:0]  gens_r, gen_cnt_r;
  logic [SizeW-1:0] rows_loaded_r;
  logic [SizeW-1:0] cnt_r;
  logic [63:0]      mem_a [MAX_SIZE];
  logic [63:0]      mem_b [MAX_SIZE];
  logic             sel_r;
  logic [63:0]      up_r, mid_r, first_r, last_row_r;
  logic [63:0]      any_r;
  logic [SizeW-1:0] top_r, right_col;

  logic [SizeW-1:0] gw, gh, lw, lh, cw;
  logic [63:0]      gm, cwm;

  function automatic logic [SizeW-1:0] clampf(input logic [SizeW-1:0] v);
    if (v == '0) return SizeW'(1);
    if (v > MaxSz) return MaxSz;
    return v;
  endfunction

  function automatic logic [63:0] maskf(input logic [SizeW-1:0] w);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 64; i++) m[i] = (SizeW'(i) < w);
    return m;
  endfunction

  assign gw  = clampf(gw_cfg_r);
  assign gh  = clampf(gh_cfg_r);
  assign lw  = clampf(lw_cfg_r);
  assign lh  = clampf(lh_cfg_r);
  assign cw  = (lw < gw) ? lw : gw;
  assign gm  = maskf(gw);
  assign cwm = maskf(cw);

  // shared row update unit
  function automatic logic [63:0] from_left(input logic [63:0] x,
                                            input logic [SizeW-1:0] w, input logic t,
                                            input logic [63:0] m);
    logic [63:0] r;
    r = x << 1;
    if (t) r = r | (x >> (w - SizeW'(1)));
    return r & m;
  endfunction

  function automatic logic [63:0] from_right(input logic [63:0] x,
                                             input logic [SizeW-1:0] w, input logic t,
                                             input logic [63:0] m);
    logic [63:0] r;
    r = x >> 1;
    if (t) r = r | (x << (w - SizeW'(1)));
    return r & m;
  endfunction

  // Generation sweep: while cnt_r is c, row c is read (c < gh) and row c-2 is updated.
  // Window: up=row c-3, mid=row c-2 registered, dn=row c-1 straight from the read register.
  logic [AW-1:0]    rd_addr;
  logic [63:0]      rd_row_r;
  logic [SizeW-1:0] ghm1;
  logic [63:0]      dn_val;
  assign ghm1 = gh - SizeW'(1);

  logic [63:0] nb [8];
  logic [63:0] s0, s1, s2, c0, c1, new_row;
  always_comb begin
    nb[0] = from_left(up_r, gw, wrap_r, gm);
    nb[1] = up_r;
    nb[2] = from_right(up_r, gw, wrap_r, gm);
    nb[3] = from_left(mid_r, gw, wrap_r, gm);
    nb[4] = from_right(mid_r, gw, wrap_r, gm);
    nb[5] = from_left(dn_val, gw, wrap_r, gm);
    nb[6] = dn_val;
    nb[7] = from_right(dn_val, gw, wrap_r, gm);
    s0 = '0; s1 = '0; s2 = '0;
    for (int k = 0; k < 8; k++) begin
      c0 = s0 & nb[k];
      s0 = s0 ^ nb[k];
      c1 = s1 & c0;
      s1 = s1 ^ c0;
      s2 = s2 ^ c1;
    end
    new_row = s1 & ~s2 & (s0 | mid_r) & gm;
  end

  always_ff @(posedge clk) begin
    if (!sel_r) rd_row_r <= mem_a[rd_addr];
    else        rd_row_r <= mem_b[rd_addr];
  end

  logic          wr_en;
  logic          wr_tgt_b;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_data;
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_tgt_b) mem_b[wr_addr] <= wr_data;
      else          mem_a[wr_addr] <= wr_data;
    end
  end

  logic [SizeW-1:0] upd_row;
  logic [SizeW-1:0] cnt_m1;
  logic             emit_go;
  assign upd_row = cnt_r - SizeW'(2);
  assign cnt_m1  = cnt_r - SizeW'(1);
  assign emit_go = !out_valid || out_ready;

  always_comb begin
    rd_addr  = cnt_r[AW-1:0];
    wr_en    = 1'b0;
    wr_tgt_b = sel_r;
    wr_addr  = cnt_r[AW-1:0];
    wr_data  = '0;
    dn_val   = rd_row_r;
    if (cnt_r == '0) dn_val = wrap_r ? last_row_r : '0;
    else if (cnt_r > gh) dn_val = wrap_r ? first_r : '0;
    unique case (state_r)
      S_IDLE: begin
        wr_en   = in_valid && in_ready;
        wr_addr = rows_loaded_r[AW-1:0];
        wr_data = (rows_loaded_r < gh) ? (in_row_bits & cwm) : '0;
      end
      S_LOAD: begin
        wr_en   = 1'b0;
      end
      S_MASK: begin
        wr_en   = mask_ph_r;
        wr_data = (cnt_r < gh && cnt_r < rows_loaded_r) ? (rd_row_r & gm) : '0;
        wr_addr = cnt_r[AW-1:0];
        rd_addr = cnt_r[AW-1:0];
      end
      S_GEN: begin
        wr_tgt_b = !sel_r;
        wr_en    = (cnt_r >= SizeW'(2));
        wr_addr  = upd_row[AW-1:0];
        wr_data  = (upd_row < gh) ? new_row : '0;
      end
      S_SCAN: begin
        rd_addr = cnt_r[AW-1:0];
      end
      S_EMIT: begin
        rd_addr = emit_go ? cnt_r[AW-1:0] : cnt_m1[AW-1:0];
      end
      default: ;
    endcase
  end

  // Loaded rows are written into the current plane; MASK reads a row, then writes it
  // back in place on the next cycle.
  logic mask_ph_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      wrap_r        <= 1'b0;
      gw_cfg_r      <= SizeW'(64);
      gh_cfg_r      <= SizeW'(64);
      lw_cfg_r      <= SizeW'(64);
      lh_cfg_r      <= SizeW'(64);
      gens_r        <= GenW'(1);
      rows_loaded_r <= '0;
      cnt_r         <= '0;
      gen_cnt_r     <= '0;
      sel_r         <= 1'b0;
      out_valid     <= 1'b0;
      mask_ph_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_WRAP_MODE:   wrap_r   <= cfg_data[0];
          REG_GRID_WIDTH:  gw_cfg_r <= cfg_data[SizeW-1:0];
          REG_GRID_HEIGHT: gh_cfg_r <= cfg_data[SizeW-1:0];
          REG_LOAD_WIDTH:  lw_cfg_r <= cfg_data[SizeW-1:0];
          REG_LOAD_HEIGHT: lh_cfg_r <= cfg_data[SizeW-1:0];
          REG_GENERATIONS: gens_r   <= cfg_data[GenW-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready && state_r != S_EMIT) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !out_valid) begin
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          // batch closes once the row count reaches the load height
          if (rows_loaded_r + SizeW'(1) >= lh) begin
            rows_loaded_r <= rows_loaded_r + SizeW'(1);
            state_r   <= S_MASK;
            cnt_r     <= '0;
            mask_ph_r <= 1'b0;
          end else begin
            rows_loaded_r <= rows_loaded_r + SizeW'(1);
            state_r <= S_IDLE;
          end
        end
        S_MASK: begin
          // two phases per row: read, then write
          if (!mask_ph_r) begin
            mask_ph_r <= 1'b1;
          end else begin
            mask_ph_r <= 1'b0;
            if (cnt_r == ghm1) last_row_r <= wr_data;
            if (cnt_r == MaxSz - SizeW'(1)) begin
              cnt_r     <= '0;
              gen_cnt_r <= '0;
              state_r   <= (gens_r == '0) ? S_SCAN : S_GEN;
            end else begin
              cnt_r <= cnt_r + SizeW'(1);
            end
          end
        end
        S_GEN: begin
          up_r  <= mid_r;
          mid_r <= dn_val;
          if (cnt_r == SizeW'(1)) first_r <= rd_row_r;
          // bottom row of this generation is the top neighbor of row 0 in the next one
          if (cnt_r >= SizeW'(2) && upd_row == ghm1) last_row_r <= new_row;
          if (cnt_r == MaxSz + SizeW'(1)) begin
            cnt_r     <= '0;
            sel_r     <= !sel_r;
            gen_cnt_r <= gen_cnt_r + GenW'(1);
            if (gen_cnt_r + GenW'(1) == gens_r) state_r <= S_SCAN;
          end else begin
            cnt_r <= cnt_r + SizeW'(1);
          end
        end
        S_SCAN: begin
          if (cnt_r == '0) begin
            any_r <= '0;
            top_r <= '0;
          end else begin
            if (rd_row_r != '0 && (cnt_r <= gh)) top_r <= cnt_r;
            if (cnt_r <= gh) any_r <= any_r | rd_row_r;
          end
          if (cnt_r == MaxSz) begin
            cnt_r   <= '0;
            state_r <= S_EMIT;
          end else begin
            cnt_r <= cnt_r + SizeW'(1);
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            if (top_r == '0) begin
              out_valid       <= 1'b1;
              out_crop_width  <= '0;
              out_crop_height <= '0;
              out_row_index   <= '0;
              out_row_bits_res <= '0;
              out_last        <= 1'b1;
              rows_loaded_r   <= '0;
              state_r         <= S_IDLE;
            end else if (cnt_r != '0) begin
              out_valid        <= 1'b1;
              out_crop_width   <= right_col;
              out_crop_height  <= top_r;
              out_row_index    <= cnt_r;
              out_row_bits_res <= rd_row_r & maskf(right_col);
              out_last         <= (cnt_r == top_r);
              if (cnt_r == top_r) begin
                rows_loaded_r <= '0;
                state_r       <= S_IDLE;
                cnt_r         <= '0;
              end else begin
                cnt_r <= cnt_r + SizeW'(1);
              end
            end else begin
              cnt_r <= SizeW'(1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // live column bound, one comparison set from the OR of all rows
  always_comb begin
    right_col = '0;
    for (int i = 0; i < 64; i++) if (any_r[i]) right_col = SizeW'(i + 1);
  end

  assign in_ready = (state_r == S_IDLE) && !out_valid;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |-> state_r == S_IDLE)
    else $error("last without batch end");
  a_rows: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> rows_loaded_r <= MaxSz) else $error("row count overrun");
endmodule
